// ===== design/particle_pair_repulsive_force_assert.svh =====
// Assertion helpers for the pair force block
`ifndef PARTICLE_PAIR_REPULSIVE_FORCE_ASSERT_SVH
`define PARTICLE_PAIR_REPULSIVE_FORCE_ASSERT_SVH

// same-cycle implication
`define PPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ppr check failed");

// next-cycle implication
`define PPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ppr check failed");

`endif

// ===== design/ppr_pkg.sv =====
package ppr_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = 33;
    localparam int RAD_W     = 31;
    localparam int RSUM_W    = 32;
    localparam int RX_W      = 33;
    localparam int SQ_W      = 66;
    localparam int SQRT_IN_W = 68;
    localparam int ROOT_W    = 34;
    localparam int REM_W     = 36;
    localparam int SQRT_STEPS = 34;
    localparam int GAP_W     = 50;
    localparam int GAP_HALF  = 25;
    localparam int PC_W      = 49;
    localparam int PC_HALF   = 24;
    localparam int K_W       = 32;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;

    localparam logic [K_W-1:0]   INV_STIFF_RST = 32'd10000000;
    localparam logic [RAD_W-1:0] CUTOFF_RST    = 31'd131072;
    localparam logic [PC_W-1:0]  PRE_LIMIT     = 49'h1_0000_0000_0000;

    typedef enum logic [1:0] {
        ZONE_OVERLAP = 2'd0,
        ZONE_NEAR    = 2'd1,
        ZONE_FAR     = 2'd2
    } zone_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_INV_STIFF = 2'd0,
        REG_CUTOFF    = 2'd1
    } cfg_reg_t;

    // per-item data carried alongside the distance calculation
    typedef struct packed {
        logic [2:0][DIFF_W-1:0] mag;
        logic [2:0]             neg;
        logic [RSUM_W-1:0]      rsum;
        logic [RX_W-1:0]        rx;
    } side_t;

endpackage

// ===== design/ppr_sqrt_stage.sv =====
// One result bit of the digit-by-digit square root, registered
module ppr_sqrt_stage (
    input  logic                               clk,
    input  logic                               adv,
    input  logic [ppr_pkg::SQRT_IN_W-1:0]      rad,
    input  logic [ppr_pkg::ROOT_W-1:0]         root,
    input  logic [ppr_pkg::REM_W-1:0]          rem,
    input  ppr_pkg::side_t                     side,
    output logic [ppr_pkg::SQRT_IN_W-1:0]      rad_out,
    output logic [ppr_pkg::ROOT_W-1:0]         root_out,
    output logic [ppr_pkg::REM_W-1:0]          rem_out,
    output ppr_pkg::side_t                     side_out
);

    logic [ppr_pkg::REM_W+1:0]     rem_sh;
    logic [ppr_pkg::REM_W+1:0]     trial;
    logic                          take;
    logic [ppr_pkg::SQRT_IN_W-1:0] rad_next;
    logic [ppr_pkg::ROOT_W-1:0]    root_next;
    logic [ppr_pkg::REM_W-1:0]     rem_next;
    logic [ppr_pkg::SQRT_IN_W-1:0] rad_reg;
    logic [ppr_pkg::ROOT_W-1:0]    root_reg;
    logic [ppr_pkg::REM_W-1:0]     rem_reg;
    ppr_pkg::side_t                side_reg;

    // bring down two radicand bits, try root*4+1
    always_comb
    begin
        rem_sh    = {rem, rad[ppr_pkg::SQRT_IN_W-1 -: 2]};
        trial     = {2'b00, root, 2'b01};
        take      = (rem_sh >= trial);
        rad_next  = {rad[ppr_pkg::SQRT_IN_W-3:0], 2'b00};
        root_next = {root[ppr_pkg::ROOT_W-2:0], take};
        rem_next  = take ? ppr_pkg::REM_W'(rem_sh - trial)
                         : ppr_pkg::REM_W'(rem_sh);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            rad_reg  <= rad_next;
            root_reg <= root_next;
            rem_reg  <= rem_next;
            side_reg <= side;
        end
    end

    assign rad_out  = rad_reg;
    assign root_out = root_reg;
    assign rem_out  = rem_reg;
    assign side_out = side_reg;

endmodule

// ===== design/ppr_force_axis.sv =====
// Force on one axis: |D|*g*k/2^16 with saturation, four register stages
module ppr_force_axis (
    input  logic                           clk,
    input  logic                           adv,
    input  logic [ppr_pkg::DIFF_W-1:0]     mag,
    input  logic                           neg,
    input  logic [ppr_pkg::GAP_W-1:0]      gap,
    input  logic [ppr_pkg::K_W-1:0]        k,
    output logic [ppr_pkg::COORD_W-1:0]    force_out,
    output logic                           sat_out
);

    localparam int PA_W = ppr_pkg::DIFF_W + ppr_pkg::GAP_HALF;
    localparam int P1_W = PA_W + ppr_pkg::GAP_HALF;
    localparam int QA_W = (ppr_pkg::PC_W - ppr_pkg::PC_HALF) + ppr_pkg::K_W;
    localparam int QB_W = ppr_pkg::PC_HALF + ppr_pkg::K_W;
    localparam int P2_W = QA_W + ppr_pkg::PC_HALF;

    logic [PA_W-1:0]             pa_reg, pb_reg, pa_next, pb_next;
    logic                        n1_reg, n2_reg, n3_reg;
    logic [P1_W-1:0]             p1;
    logic                        over1_next, over1_reg, over1_d_reg;
    logic [ppr_pkg::PC_W-1:0]    pc_next, pc_reg;
    logic [QA_W-1:0]             qa_reg, qa_next;
    logic [QB_W-1:0]             qb_reg, qb_next;
    logic [P2_W-1:0]             p2;
    logic [ppr_pkg::DIFF_W-1:0]  mag_q;
    logic                        over;
    logic [ppr_pkg::COORD_W-1:0] force_next, force_reg;
    logic                        sat_reg;

    // stage 1: partial products of |D| * g
    always_comb
    begin
        pa_next = PA_W'(mag) * PA_W'(gap[ppr_pkg::GAP_W-1:ppr_pkg::GAP_HALF]);
        pb_next = PA_W'(mag) * PA_W'(gap[ppr_pkg::GAP_HALF-1:0]);
    end

    // stage 2: assemble, check against the pre-limit
    always_comb
    begin
        p1         = {pa_reg, {ppr_pkg::GAP_HALF{1'b0}}} + P1_W'(pb_reg);
        over1_next = (p1 > P1_W'(ppr_pkg::PRE_LIMIT));
        pc_next    = over1_next ? '0 : p1[ppr_pkg::PC_W-1:0];
    end

    // stage 3: partial products of p * k
    always_comb
    begin
        qa_next = QA_W'(pc_reg[ppr_pkg::PC_W-1:ppr_pkg::PC_HALF]) * QA_W'(k);
        qb_next = QB_W'(pc_reg[ppr_pkg::PC_HALF-1:0]) * QB_W'(k);
    end

    // stage 4: assemble, clip, apply sign
    always_comb
    begin
        p2    = {qa_reg, {ppr_pkg::PC_HALF{1'b0}}} + P2_W'(qb_reg);
        mag_q = p2[ppr_pkg::PC_W-1:16];
        over  = over1_d_reg || (p2 > P2_W'(ppr_pkg::PRE_LIMIT))
                || (n3_reg ? (mag_q > 33'h0_8000_0000) : (mag_q > 33'h0_7FFF_FFFF));
        over  = over && (k != '0);
        if (over)
            force_next = n3_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else if (n3_reg)
            force_next = 32'(-mag_q[ppr_pkg::COORD_W-1:0]);
        else
            force_next = mag_q[ppr_pkg::COORD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pa_reg      <= pa_next;
            pb_reg      <= pb_next;
            n1_reg      <= neg;
            pc_reg      <= pc_next;
            over1_reg   <= over1_next;
            n2_reg      <= n1_reg;
            qa_reg      <= qa_next;
            qb_reg      <= qb_next;
            over1_d_reg <= over1_reg;
            n3_reg      <= n2_reg;
            force_reg   <= force_next;
            sat_reg     <= over;
        end
    end

    assign force_out = force_reg;
    assign sat_out   = sat_reg;

endmodule

// ===== design/particle_pair_repulsive_force.sv =====
// 43 register stages from input accept to result valid.
// Throughput: one pair per cycle unless stalled; 34 of the stages are the one-bit-per-stage square root.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// Reset (rst_n low, async) clears all valid bits and loads the register defaults.
module particle_pair_repulsive_force (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ppr_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [31:0]                first_x,
    input  logic signed [31:0]                first_y,
    input  logic signed [31:0]                first_z,
    input  logic signed [31:0]                second_x,
    input  logic signed [31:0]                second_y,
    input  logic signed [31:0]                second_z,
    input  logic [30:0]                       first_radius,
    input  logic [30:0]                       second_radius,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [31:0]                force_x,
    output logic signed [31:0]                force_y,
    output logic signed [31:0]                force_z,
    output logic [1:0]                        zone,
    output logic                              saturated
);

    localparam int NSTG  = 3 + ppr_pkg::SQRT_STEPS + 2 + 4;
    localparam int FSTG  = 4;

    logic [ppr_pkg::K_W-1:0]    inv_reg;
    logic [ppr_pkg::RAD_W-1:0]  cut_reg;
    logic [NSTG-1:0]            vld_reg;
    logic                       adv;

    logic signed [ppr_pkg::DIFF_W-1:0] diff [3];
    logic [2:0][ppr_pkg::COORD_W-1:0]  ca, cb;
    ppr_pkg::side_t             s1_next, s1_reg, s2_reg, s3_reg, z_side_reg, g_side_reg;
    logic [ppr_pkg::SQ_W-1:0]   sq_reg [3];
    logic [ppr_pkg::SQ_W-1:0]   sum_reg;

    logic [ppr_pkg::SQRT_IN_W-1:0] rad_w  [ppr_pkg::SQRT_STEPS+1];
    logic [ppr_pkg::ROOT_W-1:0]    root_w [ppr_pkg::SQRT_STEPS+1];
    logic [ppr_pkg::REM_W-1:0]     rem_w  [ppr_pkg::SQRT_STEPS+1];
    ppr_pkg::side_t                side_w [ppr_pkg::SQRT_STEPS+1];

    logic [ppr_pkg::ROOT_W-1:0]    root_d;
    ppr_pkg::zone_t                zone_next, zone_reg, g_zone_reg;
    ppr_pkg::zone_t                zd_reg [FSTG];
    logic [ppr_pkg::RSUM_W-1:0]    gz0_reg;
    logic [ppr_pkg::RX_W-1:0]      e_reg;
    logic [2*ppr_pkg::RX_W-1:0]    esq;
    logic [ppr_pkg::GAP_W-1:0]     g_next, g_reg;
    logic [2:0][ppr_pkg::COORD_W-1:0] force_w;
    logic [2:0]                    sat_w;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_reg <= ppr_pkg::INV_STIFF_RST;
            cut_reg <= ppr_pkg::CUTOFF_RST;
        end
        else if (cfg_valid)
        begin
            case (ppr_pkg::cfg_reg_t'(cfg_index))
                ppr_pkg::REG_INV_STIFF: inv_reg <= cfg_data;
                ppr_pkg::REG_CUTOFF:    cut_reg <= cfg_data[ppr_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    // global stall: the whole chain moves when the output word can leave
    assign adv      = !vld_reg[NSTG-1] || out_ready;
    assign in_ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], in_valid};
    end

    // stage 1: per-axis difference in sign-magnitude, radius sums
    assign ca = {first_z, first_y, first_x};
    assign cb = {second_z, second_y, second_x};

    always_comb
    begin
        s1_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = $signed({ca[i][31], ca[i]}) - $signed({cb[i][31], cb[i]});
            s1_next.neg[i] = diff[i][ppr_pkg::DIFF_W-1];
            s1_next.mag[i] = diff[i][ppr_pkg::DIFF_W-1]
                             ? ppr_pkg::DIFF_W'(-diff[i]) : ppr_pkg::DIFF_W'(diff[i]);
        end
        s1_next.rsum = ppr_pkg::RSUM_W'(first_radius) + ppr_pkg::RSUM_W'(second_radius);
        s1_next.rx   = ppr_pkg::RX_W'(s1_next.rsum) + ppr_pkg::RX_W'(cut_reg);
    end

    // stages 1-3: difference, squares, sum of squares
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg <= s1_next;
            for (int i = 0; i < 3; i++)
                sq_reg[i] <= ppr_pkg::SQ_W'(s1_reg.mag[i]) * ppr_pkg::SQ_W'(s1_reg.mag[i]);
            s2_reg  <= s1_reg;
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
            s3_reg  <= s2_reg;
        end
    end

    // square root chain, one result bit per stage
    assign rad_w[0]  = ppr_pkg::SQRT_IN_W'(sum_reg);
    assign root_w[0] = '0;
    assign rem_w[0]  = '0;
    assign side_w[0] = s3_reg;

    for (genvar j = 0; j < ppr_pkg::SQRT_STEPS; j++)
    begin : g_sqrt
        ppr_sqrt_stage u_stage (
            .clk      (clk),
            .adv      (adv),
            .rad      (rad_w[j]),
            .root     (root_w[j]),
            .rem      (rem_w[j]),
            .side     (side_w[j]),
            .rad_out  (rad_w[j+1]),
            .root_out (root_w[j+1]),
            .rem_out  (rem_w[j+1]),
            .side_out (side_w[j+1])
        );
    end

    assign root_d = root_w[ppr_pkg::SQRT_STEPS];

    // zone decision
    always_comb
    begin
        if (root_d <= ppr_pkg::ROOT_W'(side_w[ppr_pkg::SQRT_STEPS].rsum))
            zone_next = ppr_pkg::ZONE_OVERLAP;
        else if (root_d <= ppr_pkg::ROOT_W'(side_w[ppr_pkg::SQRT_STEPS].rx))
            zone_next = ppr_pkg::ZONE_NEAR;
        else
            zone_next = ppr_pkg::ZONE_FAR;
    end

    // gap: linear when overlapping, squared inside the cutoff band, zero beyond it
    assign esq = (2*ppr_pkg::RX_W)'(e_reg) * (2*ppr_pkg::RX_W)'(e_reg);

    always_comb
    begin
        case (zone_reg)
            ppr_pkg::ZONE_OVERLAP: g_next = ppr_pkg::GAP_W'(gz0_reg);
            ppr_pkg::ZONE_NEAR:    g_next = esq[2*ppr_pkg::RX_W-1:16];
            default:               g_next = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            zone_reg   <= zone_next;
            gz0_reg    <= ppr_pkg::RSUM_W'(ppr_pkg::ROOT_W'(side_w[ppr_pkg::SQRT_STEPS].rsum)
                                           - root_d);
            e_reg      <= ppr_pkg::RX_W'(ppr_pkg::ROOT_W'(side_w[ppr_pkg::SQRT_STEPS].rx)
                                         - root_d);
            z_side_reg <= side_w[ppr_pkg::SQRT_STEPS];
            g_reg      <= g_next;
            g_zone_reg <= zone_reg;
            g_side_reg <= z_side_reg;
            zd_reg[0]  <= g_zone_reg;
            for (int i = 1; i < FSTG; i++)
                zd_reg[i] <= zd_reg[i-1];
        end
    end

    // per-axis force units
    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        ppr_force_axis u_axis (
            .clk       (clk),
            .adv       (adv),
            .mag       (g_side_reg.mag[a]),
            .neg       (g_side_reg.neg[a]),
            .gap       (g_reg),
            .k         (inv_reg),
            .force_out (force_w[a]),
            .sat_out   (sat_w[a])
        );
    end

    assign out_valid = vld_reg[NSTG-1];
    assign force_x   = force_w[0];
    assign force_y   = force_w[1];
    assign force_z   = force_w[2];
    assign zone      = zd_reg[FSTG-1];
    assign saturated = |sat_w;

`include "particle_pair_repulsive_force_assert.svh"

    `PPR_ASSERT_NOW(a_far_zero, out_valid && zone == ppr_pkg::ZONE_FAR,
        force_x == 0 && force_y == 0 && force_z == 0 && !saturated)
    `PPR_ASSERT_NOW(a_sat_zone, out_valid && saturated, zone != ppr_pkg::ZONE_FAR)
    `PPR_ASSERT_NOW(a_zero_k, out_valid && inv_reg == '0,
        force_x == 0 && force_y == 0 && force_z == 0 && !saturated)
    `PPR_ASSERT_NEXT(a_cfg_k, cfg_valid && cfg_index == ppr_pkg::REG_INV_STIFF,
        inv_reg == $past(cfg_data))

endmodule

// ===== bench/particle_pair_repulsive_force_test.sv =====
module particle_pair_repulsive_force_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_PAIRS  = 185;

    typedef struct {
        logic signed [31:0] c1x, c1y, c1z, c2x, c2y, c2z;
        logic [30:0]        r1, r2;
    } pair_t;

    typedef struct {
        logic signed [31:0] fx, fy, fz;
        ppr_pkg::zone_t     zn;
        logic               sat;
    } force_t;

    // directed row: typed result used only where known flag is set
    typedef struct {
        pair_t  p;
        bit     known;
        force_t f;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [ppr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [ppr_pkg::CFG_DATA_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [31:0] first_x = '0, first_y = '0, first_z = '0;
    logic signed [31:0] second_x = '0, second_y = '0, second_z = '0;
    logic [30:0] first_radius = '0, second_radius = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic signed [31:0] force_x, force_y, force_z;
    logic [1:0] zone;
    logic saturated;

    // shadow of the register file
    logic [31:0] stiff_k;
    logic [30:0] cutoff;

    force_t expected_forces[$];
    bit     directed_known[$];
    force_t directed_typed[$];
    int     fail_count = 0;
    int     cycle_count = 0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    particle_pair_repulsive_force DUT (.*);

    always #4 clk = ~clk;

    // per-axis force: sign(D) * floor(|D|*g*k / 2^16), clipped
    function automatic logic [31:0] axis_force(logic signed [32:0] dv, logic [63:0] g,
                                               logic [31:0] k, ref logic sat);
        logic [32:0]  m;
        logic [127:0] p;
        logic [127:0] mag;
        m = dv[32] ? 33'(-dv) : 33'(dv);
        if (m == 0 || g == 0 || k == 0)
            return 32'd0;
        p = 128'(m) * 128'(g) * 128'(k);
        mag = p >> 16;
        if (p > 128'h1_0000_0000_0000 ||
            (dv[32] ? (mag > 128'h8000_0000) : (mag > 128'h7FFF_FFFF)))
        begin
            sat = 1'b1;
            return dv[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return dv[32] ? 32'(-mag[31:0]) : mag[31:0];
    endfunction

    function automatic force_t pair_force(pair_t p);
        force_t f;
        logic signed [32:0] dv[3];
        logic [32:0] m;
        logic [67:0] sq, cc;
        logic [33:0] r, c;
        logic [32:0] rsum, rx;
        logic [63:0] g, e;
        logic sat;
        dv[0] = {p.c1x[31], p.c1x} - {p.c2x[31], p.c2x};
        dv[1] = {p.c1y[31], p.c1y} - {p.c2y[31], p.c2y};
        dv[2] = {p.c1z[31], p.c1z} - {p.c2z[31], p.c2z};
        sq = '0;
        for (int i = 0; i < 3; i++)
        begin
            m = dv[i][32] ? 33'(-dv[i]) : 33'(dv[i]);
            sq = sq + 68'(m) * 68'(m);
        end
        // exact floor square root, one bit at a time
        r = '0;
        for (int b = 33; b >= 0; b--)
        begin
            c = r | (34'd1 << b);
            cc = 68'(c);
            if (cc * cc <= sq)
                r = c;
        end
        rsum = 33'(p.r1) + 33'(p.r2);
        rx = rsum + 33'(cutoff);
        g = '0;
        sat = 1'b0;
        if (34'(r) <= 34'(rsum))
        begin
            f.zn = ppr_pkg::ZONE_OVERLAP;
            g = 64'(rsum) - 64'(r);
        end
        else if (34'(r) <= 34'(rx))
        begin
            f.zn = ppr_pkg::ZONE_NEAR;
            e = 64'(rx) - 64'(r);
            g = (e * e) >> 16;
        end
        else
            f.zn = ppr_pkg::ZONE_FAR;
        if (f.zn == ppr_pkg::ZONE_FAR)
        begin
            f.fx = '0;
            f.fy = '0;
            f.fz = '0;
        end
        else
        begin
            f.fx = axis_force(dv[0], g, stiff_k, sat);
            f.fy = axis_force(dv[1], g, stiff_k, sat);
            f.fz = axis_force(dv[2], g, stiff_k, sat);
        end
        f.sat = sat;
        return f;
    endfunction

    // cycle limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // receiver stalls
    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    // predict on each accepted input word
    always @(posedge clk)
    begin
        pair_t p;
        if (rst_n && in_valid && in_ready)
        begin
            p.c1x = first_x;  p.c1y = first_y;  p.c1z = first_z;
            p.c2x = second_x; p.c2y = second_y; p.c2z = second_z;
            p.r1 = first_radius; p.r2 = second_radius;
            if (directed_known.size() > 0)
            begin
                if (directed_known.pop_front())
                    expected_forces.push_back(directed_typed.pop_front());
                else
                begin
                    void'(directed_typed.pop_front());
                    expected_forces.push_back(pair_force(p));
                end
            end
            else
                expected_forces.push_back(pair_force(p));
        end
    end

    // compare each result word with the oldest prediction
    always @(posedge clk)
    begin
        force_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_forces.size() == 0)
            begin
                $error("unexpected result word");
                fail_count++;
            end
            else
            begin
                w = expected_forces.pop_front();
                if (force_x !== w.fx)
                begin
                    $error("force_x expected %0d got %0d", w.fx, force_x);
                    fail_count++;
                end
                if (force_y !== w.fy)
                begin
                    $error("force_y expected %0d got %0d", w.fy, force_y);
                    fail_count++;
                end
                if (force_z !== w.fz)
                begin
                    $error("force_z expected %0d got %0d", w.fz, force_z);
                    fail_count++;
                end
                if (zone !== w.zn)
                begin
                    $error("zone expected %0d got %0d", w.zn, zone);
                    fail_count++;
                end
                if (saturated !== w.sat)
                begin
                    $error("saturated expected %0d got %0d", w.sat, saturated);
                    fail_count++;
                end
            end
        end
    end

    task automatic send_pair(pair_t p);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        first_x <= p.c1x;  first_y <= p.c1y;  first_z <= p.c1z;
        second_x <= p.c2x; second_y <= p.c2y; second_z <= p.c2z;
        first_radius <= p.r1;
        second_radius <= p.r2;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // leaves cfg_valid high so writes can follow back to back
    task automatic write_reg(logic [ppr_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == ppr_pkg::REG_INV_STIFF)
            stiff_k = val;
        else if (idx == ppr_pkg::REG_CUTOFF)
            cutoff = val[30:0];
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_forces.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    // mostly pairs at a random common scale so all three zones show up
    function automatic pair_t random_pair();
        pair_t p;
        int s;
        logic [31:0] mk;
        logic [30:0] rk;
        p.c1x = $urandom; p.c1y = $urandom; p.c1z = $urandom;
        p.c2x = $urandom; p.c2y = $urandom; p.c2z = $urandom;
        p.r1 = 31'($urandom);  p.r2 = 31'($urandom);
        if ($urandom_range(99) < 15)
            return p;
        s = $urandom_range(31, 1);
        mk = (s >= 32) ? 32'hFFFF_FFFF : ((32'd1 << s) - 1);
        rk = (s >= 31) ? 31'h7FFF_FFFF : ((31'd1 << s) - 1);
        p.c2x = p.c1x - (($urandom & mk) - (mk >> 1));
        p.c2y = p.c1y - (($urandom & mk) - (mk >> 1));
        p.c2z = p.c1z - (($urandom & mk) - (mk >> 1));
        p.r1 = p.r1 & (rk >> 1);
        p.r2 = p.r2 & (rk >> 1);
        return p;
    endfunction

    function automatic pair_t mk_pair(int x1, int y1, int z1, int x2, int y2, int z2,
                                      int ra, int rb);
        pair_t p;
        p.c1x = x1; p.c1y = y1; p.c1z = z1;
        p.c2x = x2; p.c2y = y2; p.c2z = z2;
        p.r1 = 31'(ra);  p.r2 = 31'(rb);
        return p;
    endfunction

    function automatic force_t mk_force(int fx, int fy, int fz, ppr_pkg::zone_t zn, bit sat);
        force_t f;
        f.fx = fx; f.fy = fy; f.fz = fz; f.zn = zn; f.sat = sat;
        return f;
    endfunction

    localparam int MAXI = 32'h7FFF_FFFF;
    localparam int MINI = 32'h8000_0000;
    localparam int ONE  = 32'h0001_0000;

    initial
    begin
        row_t rows[$];
        row_t rw;
        force_t none;
        none = mk_force(0, 0, 0, ppr_pkg::ZONE_FAR, 0);
        stiff_k = ppr_pkg::INV_STIFF_RST;
        cutoff = ppr_pkg::CUTOFF_RST;

        // directed rows; typed results only where obvious
        rows.push_back('{mk_pair(0, 0, 0, 0, 0, 0, 0, 0), 1,
                         mk_force(0, 0, 0, ppr_pkg::ZONE_OVERLAP, 0)});
        rows.push_back('{mk_pair(5, 6, 7, 5, 6, 7, MAXI, MAXI), 1,
                         mk_force(0, 0, 0, ppr_pkg::ZONE_OVERLAP, 0)});
        rows.push_back('{mk_pair(MAXI, MAXI, MAXI, MINI, MINI, MINI, 0, 0), 1,
                         mk_force(0, 0, 0, ppr_pkg::ZONE_FAR, 0)});
        rows.push_back('{mk_pair(MINI, 0, 0, MAXI, 0, 0, 0, 0), 1, none});
        rows.push_back('{mk_pair(100 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 1, none});
        rows.push_back('{mk_pair(MAXI, 0, 0, MINI, 0, 0, MAXI, MAXI), 0, none});
        rows.push_back('{mk_pair(MINI, MINI, MINI, MAXI, MAXI, MAXI, MAXI, MAXI), 0, none});
        rows.push_back('{mk_pair(ONE, 0, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(0, ONE, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(0, 0, -ONE, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(3 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(2 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(4 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(-4 * ONE, 0, 0, 0, 0, 0, ONE, ONE), 0, none});
        rows.push_back('{mk_pair(4 * ONE + 1, 0, 0, 0, 0, 0, ONE, ONE), 1, none});
        rows.push_back('{mk_pair(1, 1, 1, 0, 0, 0, 0, 0), 0, none});
        rows.push_back('{mk_pair(-1, -1, -1, 0, 0, 0, 1, 0), 0, none});
        rows.push_back('{mk_pair(ONE, -ONE, ONE, -ONE, ONE, -ONE, MAXI, 0), 0, none});
        rows.push_back('{mk_pair(ONE, 2 * ONE, 0, 0, 0, 0, 0, 2 * ONE), 0, none});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            directed_known.push_back(rows[i].known);
            directed_typed.push_back(rows[i].f);
        end
        foreach (rows[i])
            send_pair(rows[i].p);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            // register settings, extremes first; bad indexes are ignored
            case (ph)
                0: begin write_reg(ppr_pkg::REG_INV_STIFF, 32'd1);
                         write_reg(ppr_pkg::REG_CUTOFF, 32'd0); end
                1: begin write_reg(ppr_pkg::REG_INV_STIFF, 32'hFFFF_FFFF);
                         write_reg(ppr_pkg::REG_CUTOFF, 32'h7FFF_FFFF); end
                2: begin write_reg(ppr_pkg::REG_INV_STIFF, 32'd0);
                         write_reg(ppr_pkg::REG_CUTOFF, 32'd131072);
                         write_reg(2'd2, $urandom); write_reg(2'd3, $urandom); end
                3: begin write_reg(ppr_pkg::REG_INV_STIFF, ppr_pkg::INV_STIFF_RST);
                         write_reg(ppr_pkg::REG_CUTOFF, 32'hFFFF_FFFF); end
                default: begin write_reg(ppr_pkg::REG_INV_STIFF, $urandom_range(20000, 0));
                               write_reg(ppr_pkg::REG_CUTOFF, $urandom); end
            endcase
            cfg_valid <= 1'b0;
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 73; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 73; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            for (int n = 0; n < PHASE_PAIRS; n++)
            begin
                // quiet stretch inside each phase
                if (n == PHASE_PAIRS / 2)
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
                send_pair(random_pair());
            end
            drain();
        end

        if (fail_count == 0 && expected_forces.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
